// ===== rtl/spmd_pkg.sv =====
// spmd_pkg: shared constants, codes and transaction types for the slow pwm motor drive
// no dependencies; used by the channel interfaces, spmd_drive and the top level
package spmd_pkg;

   // defaults for the top level parameters
   localparam int PHASE_BITS_DEFAULT  = 11;
   localparam int SPEED_SHIFT_DEFAULT = 6;

   // fixed field widths
   localparam int CMD_BITS      = 16;
   localparam int TIME_BITS     = 16;
   localparam int DURATION_BITS = 16;
   localparam int RESUME_BITS   = 11;
   localparam int OP_BITS       = 2;
   localparam int STATUS_BITS   = 2;

   // operation codes
   localparam logic [OP_BITS-1:0] OP_TICK      = 2'd0;
   localparam logic [OP_BITS-1:0] OP_SET_SPEED = 2'd1;
   localparam logic [OP_BITS-1:0] OP_BOOST     = 2'd2;

   // boost status codes
   localparam logic [STATUS_BITS-1:0] BOOST_IDLE      = 2'd0;
   localparam logic [STATUS_BITS-1:0] BOOST_REQUESTED = 2'd1;
   localparam logic [STATUS_BITS-1:0] BOOST_RUNNING   = 2'd2;

   // configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOOST_DURATION = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOOST_RESUME   = 1'd1;

   // reset values
   localparam logic [DURATION_BITS-1:0] DURATION_RESET = 16'd7000;
   localparam logic [RESUME_BITS-1:0]   RESUME_RESET   = 11'h3ff;
   localparam logic [7:0]               DUTY_RESET     = 8'd140;

   typedef struct packed {
      logic [OP_BITS-1:0]          op;
      logic signed [CMD_BITS-1:0]  speed_command;
      logic                        boost_on;
      logic [TIME_BITS-1:0]        time_now;
   } req_item_type;

   typedef struct packed {
      logic                    enable_pin;
      logic                    fw_pin;
      logic                    rw_pin;
      logic [STATUS_BITS-1:0]  boost_status;
   } rsp_item_type;

   typedef struct packed {
      logic [DURATION_BITS-1:0] boost_duration;
      logic [RESUME_BITS-1:0]   boost_resume_phase;
   } csr_type;

endpackage

// ===== rtl/spmd_if.sv =====
// spmd_req_if / spmd_rsp_if: valid/ready channels for request and response transactions
// depends on spmd_pkg for field widths
interface spmd_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [spmd_pkg::OP_BITS-1:0]         op;
   logic signed [spmd_pkg::CMD_BITS-1:0] speed_command;
   logic                                 boost_on;
   logic [spmd_pkg::TIME_BITS-1:0]       time_now;

   modport source (output valid, op, speed_command, boost_on, time_now, input ready);
   modport sink (input valid, op, speed_command, boost_on, time_now, output ready);
endinterface

interface spmd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                enable_pin;
   logic                                fw_pin;
   logic                                rw_pin;
   logic [spmd_pkg::STATUS_BITS-1:0]    boost_status;

   modport source (output valid, enable_pin, fw_pin, rw_pin, boost_status, input ready);
   modport sink (input valid, enable_pin, fw_pin, rw_pin, boost_status, output ready);
endinterface

// ===== rtl/spmd_drive.sv =====
// spmd_drive: pwm phase counter, speed/direction state and boost sequencing
// depends on spmd_pkg; result is the state after the transaction being stepped
module spmd_drive #(
   parameter int PHASE_BITS  = spmd_pkg::PHASE_BITS_DEFAULT,
   parameter int SPEED_SHIFT = spmd_pkg::SPEED_SHIFT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  spmd_pkg::req_item_type item,
   input  spmd_pkg::csr_type      csr,
   output spmd_pkg::rsp_item_type result
);

   // |cmd| >> shift peaks at 2^(15-shift); keep at least 8 bits for the reset duty
   localparam int DUTY_BITS = (spmd_pkg::CMD_BITS - SPEED_SHIFT > 8) ?
                              spmd_pkg::CMD_BITS - SPEED_SHIFT : 8;
   localparam int CMP_BITS  = (PHASE_BITS > DUTY_BITS) ? PHASE_BITS : DUTY_BITS;

   logic [PHASE_BITS-1:0]              phase_ff, phase_in;
   logic [DUTY_BITS-1:0]               duty_ff, duty_in;
   logic                               dir_ff, dir_in;
   logic [spmd_pkg::STATUS_BITS-1:0]   boost_ff, boost_in;
   logic [spmd_pkg::TIME_BITS-1:0]     start_ff, start_in;
   logic                               enable_ff, enable_in;
   logic                               fw_ff, fw_in;
   logic                               rw_ff, rw_in;

   logic [spmd_pkg::CMD_BITS-1:0]      magnitude;
   logic [spmd_pkg::TIME_BITS-1:0]     elapsed;

   always_comb begin
      phase_in  = phase_ff;
      duty_in   = duty_ff;
      dir_in    = dir_ff;
      boost_in  = boost_ff;
      start_in  = start_ff;
      enable_in = enable_ff;
      fw_in     = fw_ff;
      rw_in     = rw_ff;
      // two's complement magnitude, -32768 maps to 0x8000
      magnitude = item.speed_command[spmd_pkg::CMD_BITS-1] ?
                  spmd_pkg::CMD_BITS'(-item.speed_command) :
                  spmd_pkg::CMD_BITS'(item.speed_command);
      elapsed   = spmd_pkg::TIME_BITS'(item.time_now - start_ff);
      case (item.op)
         spmd_pkg::OP_TICK: begin
            if (boost_ff == spmd_pkg::BOOST_REQUESTED) begin
               enable_in = 1'b1;
               fw_in     = dir_ff;
               rw_in     = !dir_ff;
               start_in  = item.time_now;
               boost_in  = spmd_pkg::BOOST_RUNNING;
            end else if (boost_ff == spmd_pkg::BOOST_RUNNING) begin
               if (elapsed > csr.boost_duration) begin
                  enable_in = 1'b0;
                  fw_in     = 1'b0;
                  rw_in     = 1'b0;
                  boost_in  = spmd_pkg::BOOST_IDLE;
                  phase_in  = PHASE_BITS'(csr.boost_resume_phase);
               end
            end else begin
               if (phase_ff == '0 && duty_ff != '0) begin
                  enable_in = 1'b1;
                  fw_in     = dir_ff;
                  rw_in     = !dir_ff;
               end
               // off wins when phase meets duty
               if (CMP_BITS'(phase_ff) == CMP_BITS'(duty_ff)) begin
                  enable_in = 1'b0;
                  fw_in     = 1'b0;
                  rw_in     = 1'b0;
               end
               phase_in = phase_ff + 1'b1;
            end
         end
         spmd_pkg::OP_SET_SPEED: begin
            dir_in  = item.speed_command[spmd_pkg::CMD_BITS-1];
            duty_in = DUTY_BITS'(magnitude >> SPEED_SHIFT);
         end
         spmd_pkg::OP_BOOST: begin
            if (item.boost_on && boost_ff == spmd_pkg::BOOST_IDLE) begin
               boost_in = spmd_pkg::BOOST_REQUESTED;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         duty_ff   <= DUTY_BITS'(spmd_pkg::DUTY_RESET);
         dir_ff    <= 1'b0;
         boost_ff  <= spmd_pkg::BOOST_IDLE;
         start_ff  <= '0;
         enable_ff <= 1'b0;
         fw_ff     <= 1'b0;
         rw_ff     <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         duty_ff   <= duty_in;
         dir_ff    <= dir_in;
         boost_ff  <= boost_in;
         start_ff  <= start_in;
         enable_ff <= enable_in;
         fw_ff     <= fw_in;
         rw_ff     <= rw_in;
      end
   end

   assign result.enable_pin   = enable_in;
   assign result.fw_pin       = fw_in;
   assign result.rw_pin       = rw_in;
   assign result.boost_status = boost_in;

`ifndef ASSERT_OFF
   // the two direction pins are never driven together
   assert property (@(posedge clock) disable iff (reset) !(fw_ff && rw_ff))
      else $error("both direction pins on");

   // state only moves when a transaction is stepped
   assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(duty_ff) && $stable(boost_ff) && $stable(enable_ff))
      else $error("drive state changed without a transaction");

   // a tick on a pending boost starts it with drives on
   assert property (@(posedge clock) disable iff (reset)
      step && item.op == spmd_pkg::OP_TICK && boost_ff == spmd_pkg::BOOST_REQUESTED
      |=> boost_ff == spmd_pkg::BOOST_RUNNING && enable_ff)
      else $error("boost did not start on tick");

   // phase counter holds while a boost is running and not expired
   assert property (@(posedge clock) disable iff (reset)
      step && boost_ff == spmd_pkg::BOOST_RUNNING && boost_in == spmd_pkg::BOOST_RUNNING
      |=> $stable(phase_ff) && enable_ff)
      else $error("phase moved during boost");
`endif

endmodule

// ===== rtl/slow_pwm_motor_drive_with_boost_top.sv =====
// slow_pwm_motor_drive_with_boost_top: channel registers, csr file and the drive core
// depends on spmd_pkg, spmd_req_if/spmd_rsp_if and spmd_drive
//
//   channel   direction  handshake        payload
//   req_ch    in         valid/ready      op, speed_command, boost_on, time_now
//   rsp_ch    out        valid/ready      enable_pin, fw_pin, rw_pin, boost_status
//   csr_*     in         csr_we only      csr_index, csr_wdata
//
// one transaction per cycle sustained while rsp_ch is not stalled; a request passes through
// the input register, then the response register loaded with the updated drive state
// synchronous active-high reset clears valids, drive state and csr defaults
// a stalled response holds in its register; the input register keeps taking
// transactions as long as the response register can move
module slow_pwm_motor_drive_with_boost_top #(
   parameter int PHASE_BITS  = spmd_pkg::PHASE_BITS_DEFAULT,
   parameter int SPEED_SHIFT = spmd_pkg::SPEED_SHIFT_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   spmd_req_if.sink                              req_ch,
   spmd_rsp_if.source                            rsp_ch,
   input  logic                                  csr_we,
   input  logic [spmd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [spmd_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   logic                   in_valid_ff;
   spmd_pkg::req_item_type in_item_ff;
   logic                   out_valid_ff;
   spmd_pkg::rsp_item_type out_item_ff;
   spmd_pkg::csr_type      csr_ff;
   spmd_pkg::rsp_item_type result;
   logic                   advance;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.boost_duration     <= spmd_pkg::DURATION_RESET;
         csr_ff.boost_resume_phase <= spmd_pkg::RESUME_RESET;
      end else if (csr_we) begin
         case (csr_index)
            spmd_pkg::CSR_BOOST_DURATION:
               csr_ff.boost_duration <= spmd_pkg::DURATION_BITS'(csr_wdata);
            spmd_pkg::CSR_BOOST_RESUME:
               csr_ff.boost_resume_phase <= spmd_pkg::RESUME_BITS'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_item_ff.op            <= req_ch.op;
         in_item_ff.speed_command <= req_ch.speed_command;
         in_item_ff.boost_on      <= req_ch.boost_on;
         in_item_ff.time_now      <= req_ch.time_now;
      end
   end

   spmd_drive #(
      .PHASE_BITS  (PHASE_BITS),
      .SPEED_SHIFT (SPEED_SHIFT)
   ) u_drive (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .csr    (csr_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ch.ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.enable_pin   = out_item_ff.enable_pin;
   assign rsp_ch.fw_pin       = out_item_ff.fw_pin;
   assign rsp_ch.rw_pin       = out_item_ff.rw_pin;
   assign rsp_ch.boost_status = out_item_ff.boost_status;

endmodule
